// ----- hdl/pwrr_pkg.sv -----
// Package for the priority / weighted round robin descriptor scheduler.
// Sizes, register codes, policy and opcode encodings, FSM states and
// the structs between the sequencer, pointer unit and queue RAM. No dependencies.
`default_nettype none

package pwrr_pkg;

  localparam int QUEUE_DEPTH    = 64;
  localparam int NUM_PRIORITIES = 8;
  localparam int NUM_QUEUES     = NUM_PRIORITIES + 1;
  localparam int ARRIVAL_Q      = NUM_PRIORITIES;
  localparam int MEM_DEPTH      = NUM_QUEUES * QUEUE_DEPTH;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = PTR_W + 1;
  localparam int QIDX_W = $clog2(NUM_QUEUES);
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  localparam int ID_W      = 16;
  localparam int PRI_W     = 3;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int WGT_W     = 4;
  localparam int PCNT_W    = 4;
  localparam int MAX_RUN   = 16;
  localparam int RUN_W     = 5;

  localparam logic [CFG_W-1:0]  WEIGHTS_RST     = 32'h1112_2235;
  localparam logic [RUN_W-1:0]  ROUND_LIMIT_RST = RUN_W'(MAX_RUN);
  localparam logic [PCNT_W-1:0] PRIO_COUNT_RST  = PCNT_W'(NUM_PRIORITIES);

  typedef enum logic [1:0] {
    POL_SP   = 2'd0,
    POL_WRR  = 2'd1,
    POL_FIFO = 2'd2,
    POL_RSV  = 2'd3
  } policy_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLICY      = 2'd0,
    CFG_WEIGHTS     = 2'd1,
    CFG_ROUND_LIMIT = 2'd2,
    CFG_PRIO_COUNT  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ,
    ST_SCAN,
    ST_READ,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [QIDX_W-1:0] q;
    logic              push;
    logic              pop;
  } ptr_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] head_addr;
    logic [ADDR_W-1:0] tail_addr;
    logic              full;
    logic              empty;
  } ptr_rsp_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   wdata;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    logic             last;
    logic             drop;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/pwrr_ram.sv -----
// Single-port descriptor store holding all queues back to back.
// Registered read data. Depends on pwrr_pkg.
`default_nettype none

module pwrr_ram (
  input  wire                          clk_i,
  input  pwrr_pkg::mem_req_t           req_i,
  output logic [pwrr_pkg::ID_W-1:0]    rdata_o
);

  logic [pwrr_pkg::ID_W-1:0] mem [pwrr_pkg::MEM_DEPTH];
  logic [pwrr_pkg::ID_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en && req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en && !req_i.we) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/pwrr_ptrs.sv -----
// Per-queue head pointers and fill counts with RAM address generation.
// One queue is served per cycle. Depends on pwrr_pkg.
`default_nettype none

module pwrr_ptrs (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  pwrr_pkg::ptr_req_t  req_i,
  output pwrr_pkg::ptr_rsp_t  rsp_o
);

  logic [pwrr_pkg::PTR_W-1:0]  heads_q [pwrr_pkg::NUM_QUEUES];
  logic [pwrr_pkg::FILL_W-1:0] fill_q  [pwrr_pkg::NUM_QUEUES];

  logic [pwrr_pkg::PTR_W-1:0]  head;
  logic [pwrr_pkg::PTR_W-1:0]  head_nxt;
  logic [pwrr_pkg::FILL_W-1:0] fill;
  logic [pwrr_pkg::PTR_W:0]    tail_sum;
  logic [pwrr_pkg::PTR_W-1:0]  tail;
  logic [pwrr_pkg::ADDR_W-1:0] base;

  always_comb begin
    head     = heads_q[req_i.q];
    fill     = fill_q[req_i.q];
    tail_sum = {1'b0, head} + (pwrr_pkg::PTR_W+1)'(fill);
    if (tail_sum >= (pwrr_pkg::PTR_W+1)'(pwrr_pkg::QUEUE_DEPTH)) begin
      tail = pwrr_pkg::PTR_W'(tail_sum - (pwrr_pkg::PTR_W+1)'(pwrr_pkg::QUEUE_DEPTH));
    end else begin
      tail = pwrr_pkg::PTR_W'(tail_sum);
    end
    if (head == pwrr_pkg::PTR_W'(pwrr_pkg::QUEUE_DEPTH - 1)) begin
      head_nxt = '0;
    end else begin
      head_nxt = head + 1'b1;
    end
    base = pwrr_pkg::ADDR_W'(req_i.q) * pwrr_pkg::ADDR_W'(pwrr_pkg::QUEUE_DEPTH);
  end

  assign rsp_o.head_addr = base + pwrr_pkg::ADDR_W'(head);
  assign rsp_o.tail_addr = base + pwrr_pkg::ADDR_W'(tail);
  assign rsp_o.full      = (fill == pwrr_pkg::FILL_W'(pwrr_pkg::QUEUE_DEPTH));
  assign rsp_o.empty     = (fill == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pwrr_pkg::NUM_QUEUES; i++) begin
        heads_q[i] <= '0;
        fill_q[i]  <= '0;
      end
    end else if (req_i.push) begin
      fill_q[req_i.q] <= fill + 1'b1;
    end else if (req_i.pop) begin
      heads_q[req_i.q] <= head_nxt;
      fill_q[req_i.q]  <= fill - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pwrr_ctrl.sv -----
// Sequencer: configuration registers, enqueue check and the queue scan
// that pops one descriptor per step. Depends on pwrr_pkg.
`default_nettype none

module pwrr_ctrl (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start_i,
  input  wire                                opcode_i,
  input  wire [pwrr_pkg::ID_W-1:0]           descriptor_id_i,
  input  wire [pwrr_pkg::PRI_W-1:0]          priority_level_i,
  input  wire                                cfg_we_i,
  input  wire [pwrr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire [pwrr_pkg::CFG_W-1:0]          cfg_wdata_i,
  output logic                               busy_o,
  output pwrr_pkg::result_t                  result_o,
  output pwrr_pkg::ptr_req_t                 ptr_req_o,
  input  pwrr_pkg::ptr_rsp_t                 ptr_rsp_i,
  output pwrr_pkg::mem_req_t                 mem_req_o,
  input  wire [pwrr_pkg::ID_W-1:0]           mem_rdata_i
);

  pwrr_pkg::state_e  state_q, state_d;
  pwrr_pkg::policy_e policy_q;

  logic [pwrr_pkg::CFG_W-1:0]  weights_q;
  logic [pwrr_pkg::RUN_W-1:0]  round_limit_q;
  logic [pwrr_pkg::PCNT_W-1:0] prio_count_q;

  logic [pwrr_pkg::ID_W-1:0]   id_q, id_d;
  logic [pwrr_pkg::PRI_W-1:0]  lvl_q, lvl_d;
  logic [pwrr_pkg::QIDX_W-1:0] qidx_q, qidx_d;
  logic [pwrr_pkg::RUN_W-1:0]  count_q, count_d;
  logic [pwrr_pkg::WGT_W-1:0]  jcnt_q, jcnt_d;
  logic                        pend_v_q, pend_v_d;
  logic [pwrr_pkg::ID_W-1:0]   pend_id_q, pend_id_d;
  logic [pwrr_pkg::PRI_W-1:0]  pend_pri_q, pend_pri_d;
  logic [pwrr_pkg::PRI_W-1:0]  rd_pri_q, rd_pri_d;
  pwrr_pkg::result_t           res_q, res_d;

  logic [pwrr_pkg::PCNT_W-1:0] pc;
  logic [pwrr_pkg::RUN_W-1:0]  limit;
  logic [pwrr_pkg::WGT_W-1:0]  wgt;
  logic [pwrr_pkg::QIDX_W-1:0] enq_q;
  logic                        enq_refuse;
  logic                        scan_end;
  logic                        scan_pop;
  logic                        push;
  logic                        pop;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q      <= pwrr_pkg::POL_SP;
      weights_q     <= pwrr_pkg::WEIGHTS_RST;
      round_limit_q <= pwrr_pkg::ROUND_LIMIT_RST;
      prio_count_q  <= pwrr_pkg::PRIO_COUNT_RST;
    end else if (cfg_we_i) begin
      case (pwrr_pkg::cfg_idx_e'(cfg_idx_i))
        pwrr_pkg::CFG_POLICY:      policy_q <= pwrr_pkg::policy_e'(cfg_wdata_i[1:0]);
        pwrr_pkg::CFG_WEIGHTS:     weights_q <= cfg_wdata_i;
        pwrr_pkg::CFG_ROUND_LIMIT: round_limit_q <= cfg_wdata_i[pwrr_pkg::RUN_W-1:0];
        pwrr_pkg::CFG_PRIO_COUNT:  prio_count_q <= cfg_wdata_i[pwrr_pkg::PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // decode
  always_comb begin
    if (prio_count_q == '0) begin
      pc = pwrr_pkg::PCNT_W'(1);
    end else if (prio_count_q > pwrr_pkg::PCNT_W'(pwrr_pkg::NUM_PRIORITIES)) begin
      pc = pwrr_pkg::PCNT_W'(pwrr_pkg::NUM_PRIORITIES);
    end else begin
      pc = prio_count_q;
    end
    if (round_limit_q == '0) begin
      limit = pwrr_pkg::RUN_W'(1);
    end else if (round_limit_q > pwrr_pkg::RUN_W'(pwrr_pkg::MAX_RUN)) begin
      limit = pwrr_pkg::RUN_W'(pwrr_pkg::MAX_RUN);
    end else begin
      limit = round_limit_q;
    end
    wgt = weights_q[pwrr_pkg::WGT_W*qidx_q[pwrr_pkg::PRI_W-1:0] +: pwrr_pkg::WGT_W];

    if (policy_q == pwrr_pkg::POL_FIFO) begin
      enq_q = pwrr_pkg::QIDX_W'(pwrr_pkg::ARRIVAL_Q);
    end else begin
      enq_q = pwrr_pkg::QIDX_W'(lvl_q);
    end
    enq_refuse = ptr_rsp_i.full ||
                 ((policy_q != pwrr_pkg::POL_FIFO) && (pwrr_pkg::PCNT_W'(lvl_q) >= pc));

    case (policy_q)
      pwrr_pkg::POL_SP: begin
        scan_end = (pwrr_pkg::PCNT_W'(qidx_q) >= pc);
        scan_pop = !scan_end && !ptr_rsp_i.empty;
      end
      pwrr_pkg::POL_WRR: begin
        scan_end = (count_q >= limit) || (pwrr_pkg::PCNT_W'(qidx_q) >= pc);
        scan_pop = !scan_end && !ptr_rsp_i.empty && (jcnt_q < wgt);
      end
      pwrr_pkg::POL_FIFO: begin
        scan_end = ptr_rsp_i.empty;
        scan_pop = !ptr_rsp_i.empty;
      end
      default: begin
        scan_end = 1'b1;
        scan_pop = 1'b0;
      end
    endcase

    push = (state_q == pwrr_pkg::ST_ENQ) && !enq_refuse;
    pop  = (state_q == pwrr_pkg::ST_SCAN) && scan_pop;
  end

  always_comb begin
    ptr_req_o.q    = (state_q == pwrr_pkg::ST_ENQ) ? enq_q : qidx_q;
    ptr_req_o.push = push;
    ptr_req_o.pop  = pop;
    mem_req_o.en    = push || pop;
    mem_req_o.we    = push;
    mem_req_o.addr  = push ? ptr_rsp_i.tail_addr : ptr_rsp_i.head_addr;
    mem_req_o.wdata = id_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pwrr_pkg::ST_IDLE: begin
        if (start_i) begin
          if (pwrr_pkg::opcode_e'(opcode_i) == pwrr_pkg::OP_ENQ) begin
            state_d = pwrr_pkg::ST_ENQ;
          end else if (policy_q != pwrr_pkg::POL_RSV) begin
            state_d = pwrr_pkg::ST_SCAN;
          end
        end
      end
      pwrr_pkg::ST_ENQ:  state_d = pwrr_pkg::ST_IDLE;
      pwrr_pkg::ST_SCAN: begin
        if (scan_pop) begin
          state_d = pwrr_pkg::ST_READ;
        end else if (scan_end) begin
          state_d = pwrr_pkg::ST_FIN;
        end
      end
      pwrr_pkg::ST_READ: begin
        state_d = (policy_q == pwrr_pkg::POL_WRR) ? pwrr_pkg::ST_SCAN : pwrr_pkg::ST_FIN;
      end
      pwrr_pkg::ST_FIN:  state_d = pwrr_pkg::ST_IDLE;
      default:           state_d = pwrr_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    id_d       = id_q;
    lvl_d      = lvl_q;
    qidx_d     = qidx_q;
    count_d    = count_q;
    jcnt_d     = jcnt_q;
    pend_v_d   = pend_v_q;
    pend_id_d  = pend_id_q;
    pend_pri_d = pend_pri_q;
    rd_pri_d   = rd_pri_q;
    res_d       = res_q;
    res_d.valid = 1'b0;
    case (state_q)
      pwrr_pkg::ST_IDLE: begin
        if (start_i) begin
          id_d     = descriptor_id_i;
          lvl_d    = priority_level_i;
          qidx_d   = (policy_q == pwrr_pkg::POL_FIFO) ?
                     pwrr_pkg::QIDX_W'(pwrr_pkg::ARRIVAL_Q) : '0;
          count_d  = '0;
          jcnt_d   = '0;
          pend_v_d = 1'b0;
        end
      end
      pwrr_pkg::ST_ENQ: begin
        if (enq_refuse) begin
          res_d = '{valid: 1'b1, id: id_q, pri: lvl_q, last: 1'b0, drop: 1'b1};
        end
      end
      pwrr_pkg::ST_SCAN: begin
        if (scan_pop) begin
          count_d  = count_q + 1'b1;
          jcnt_d   = jcnt_q + 1'b1;
          rd_pri_d = (qidx_q == pwrr_pkg::QIDX_W'(pwrr_pkg::ARRIVAL_Q)) ?
                     '0 : qidx_q[pwrr_pkg::PRI_W-1:0];
        end else if (!scan_end) begin
          qidx_d = qidx_q + 1'b1;
          jcnt_d = '0;
        end
      end
      pwrr_pkg::ST_READ: begin
        if (pend_v_q) begin
          res_d = '{valid: 1'b1, id: pend_id_q, pri: pend_pri_q, last: 1'b0, drop: 1'b0};
        end
        pend_v_d   = 1'b1;
        pend_id_d  = mem_rdata_i;
        pend_pri_d = rd_pri_q;
      end
      pwrr_pkg::ST_FIN: begin
        if (pend_v_q) begin
          res_d = '{valid: 1'b1, id: pend_id_q, pri: pend_pri_q, last: 1'b1, drop: 1'b0};
        end
        pend_v_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pwrr_pkg::ST_IDLE;
      qidx_q    <= '0;
      count_q   <= '0;
      jcnt_q    <= '0;
      pend_v_q  <= 1'b0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      qidx_q    <= qidx_d;
      count_q   <= count_d;
      jcnt_q    <= jcnt_d;
      pend_v_q  <= pend_v_d;
      res_q     <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    lvl_q      <= lvl_d;
    pend_id_q  <= pend_id_d;
    pend_pri_q <= pend_pri_d;
    rd_pri_q   <= rd_pri_d;
  end

  assign busy_o   = (state_q != pwrr_pkg::ST_IDLE);
  assign result_o = res_q;

endmodule

`default_nettype wire

// ----- hdl/priority_wrr_packet_scheduler.sv -----
// Priority / weighted round robin descriptor scheduler, top level.
// Usage:
//   Command channel: a transaction is accepted at a rising edge with start_i high
//   and busy_o low. opcode_i 0 enqueues descriptor_id_i on queue priority_level_i
//   (or on the arrival queue in FIFO mode); opcode_i 1 requests a dequeue run.
//   Results: result_valid_o marks one result per cycle for exactly one cycle;
//   the receiver cannot stall, so every strobed result is taken.
//   Enqueue: busy_o is high only for the enqueue state; a refused enqueue strobes
//   its result with dropped_o set from the result register after the enqueue state.
//   Dequeue: one shared pointer unit and one single-port RAM serve one queue per
//   cycle. Each scan step checks one queue; each pop adds a read state (RAM
//   read with registered data). Strict priority and FIFO mode end a run after
//   the first pop; a weighted round goes back to the scan after each read,
//   until the round limit or the last enabled priority queue ends it.
//   Results of a run never come back to back; the last has last_of_round_o.
//   Configuration: cfg_we_i / cfg_idx_i / cfg_wdata_i, written while idle.
// Reset clears all queue pointers and fill counts and loads default registers;
// the descriptor store is not cleared, as only written entries are read.
// Depends on pwrr_pkg, pwrr_ctrl, pwrr_ptrs, pwrr_ram.
`default_nettype none

module priority_wrr_packet_scheduler (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start_i,
  output logic                               busy_o,
  input  wire                                opcode_i,
  input  wire [pwrr_pkg::ID_W-1:0]           descriptor_id_i,
  input  wire [pwrr_pkg::PRI_W-1:0]          priority_level_i,
  input  wire                                cfg_we_i,
  input  wire [pwrr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire [pwrr_pkg::CFG_W-1:0]          cfg_wdata_i,
  output logic                               result_valid_o,
  output logic [pwrr_pkg::ID_W-1:0]          sent_id_o,
  output logic [pwrr_pkg::PRI_W-1:0]         sent_priority_o,
  output logic                               last_of_round_o,
  output logic                               dropped_o
);

  pwrr_pkg::ptr_req_t         ptr_req;
  pwrr_pkg::ptr_rsp_t         ptr_rsp;
  pwrr_pkg::mem_req_t         mem_req;
  logic [pwrr_pkg::ID_W-1:0]  mem_rdata;
  pwrr_pkg::result_t          result;

  pwrr_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .opcode_i         (opcode_i),
    .descriptor_id_i  (descriptor_id_i),
    .priority_level_i (priority_level_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .busy_o           (busy_o),
    .result_o         (result),
    .ptr_req_o        (ptr_req),
    .ptr_rsp_i        (ptr_rsp),
    .mem_req_o        (mem_req),
    .mem_rdata_i      (mem_rdata)
  );

  pwrr_ptrs u_ptrs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ptr_req),
    .rsp_o  (ptr_rsp)
  );

  pwrr_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign result_valid_o  = result.valid;
  assign sent_id_o       = result.id;
  assign sent_priority_o = result.pri;
  assign last_of_round_o = result.last;
  assign dropped_o       = result.drop;

endmodule

`default_nettype wire

// ----- hdl/pwrr_checker.sv -----
// Port-level checks for the descriptor scheduler, bound to the top level.
// Depends on pwrr_pkg and priority_wrr_packet_scheduler.
`default_nettype none

module pwrr_checker (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                start_i,
  input wire                                busy_o,
  input wire                                opcode_i,
  input wire [pwrr_pkg::ID_W-1:0]           descriptor_id_i,
  input wire                                result_valid_o,
  input wire [pwrr_pkg::ID_W-1:0]           sent_id_o,
  input wire                                last_of_round_o,
  input wire                                dropped_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (opcode_i == pwrr_pkg::OP_ENQ) |=> busy_o)
    else $error("busy not raised after an accepted enqueue");

  a_drop_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && dropped_o |-> !last_of_round_o)
    else $error("dropped result marked last of round");

  a_drop_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && dropped_o |->
      $past(start_i && !busy_o && (opcode_i == pwrr_pkg::OP_ENQ), 2) &&
      (sent_id_o == $past(descriptor_id_i, 2)))
    else $error("dropped result does not echo the enqueue two cycles back");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_of_round_o |=> !result_valid_o)
    else $error("result strobe directly after the end of a run");

endmodule

bind priority_wrr_packet_scheduler pwrr_checker u_pwrr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .opcode_i        (opcode_i),
  .descriptor_id_i (descriptor_id_i),
  .result_valid_o  (result_valid_o),
  .sent_id_o       (sent_id_o),
  .last_of_round_o (last_of_round_o),
  .dropped_o       (dropped_o)
);

`default_nettype wire
